>>> rtl/multi_channel_software_watchdog_unit_defines.svh
// Assertion macros used by the watchdog sequencer RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef MULTI_CHANNEL_SOFTWARE_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_SOFTWARE_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clock and disabled in reset.
`define MCSWD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mcswd: same-cycle check failed");

// Next-cycle implication, clocked on clock and disabled in reset.
`define MCSWD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mcswd: next-cycle check failed");

`endif

>>> rtl/mcswd_pkg.sv
// Package for the multi-channel watchdog: sizes, codes, types and the name trim.
// No dependencies; used by every module of the block.
package mcswd_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HANDLE_W   = 4;
   localparam int NAME_BYTES = 8;
   localparam int NAME_W     = 8 * NAME_BYTES;
   localparam int CNT_W      = 16;
   localparam int EXP_W      = 5;
   localparam logic [CNT_W-1:0] RELOAD_RESET = 16'd10;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_FEED     = 2'd1,
      OP_TICK     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_DUPLICATE  = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic              label_en;
      logic [SLOT_W-1:0] addr;
      logic [CNT_W-1:0]  count;
      logic [NAME_W-1:0] label;
   } wr_req_type;

   // A name ends at its first zero byte; every byte after it is cleared.
   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      logic              live;
      kept = '0;
      live = 1'b1;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            kept[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return kept;
   endfunction

endpackage

>>> rtl/mcswd_slot_store.sv
// Slot table of the watchdog: used flags, counter memory and label memory.
// Depends on mcswd_pkg; one write port and one registered read port.
module mcswd_slot_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mcswd_pkg::wr_req_type                  wr,
   input  logic [mcswd_pkg::SLOT_W-1:0]           rd_addr,
   output logic [mcswd_pkg::CNT_W-1:0]            rd_count,
   output logic [mcswd_pkg::NAME_W-1:0]           rd_label,
   output logic [mcswd_pkg::SLOTS-1:0]            used
);

   logic [mcswd_pkg::CNT_W-1:0]  count_mem [mcswd_pkg::SLOTS];
   logic [mcswd_pkg::NAME_W-1:0] label_mem [mcswd_pkg::SLOTS];
   logic [mcswd_pkg::CNT_W-1:0]  rd_count_ff;
   logic [mcswd_pkg::NAME_W-1:0] rd_label_ff;
   logic [mcswd_pkg::SLOTS-1:0]  used_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         count_mem[wr.addr] <= wr.count;
      end
      if (wr.label_en) begin
         label_mem[wr.addr] <= wr.label;
      end
      rd_count_ff <= count_mem[rd_addr];
      rd_label_ff <= label_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr.label_en) begin
         used_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_count = rd_count_ff;
   assign rd_label = rd_label_ff;
   assign used     = used_ff;

endmodule

>>> rtl/mcswd_seq.sv
// Sequencer and shared compare/decrement unit that walks the slot table.
// Depends on mcswd_pkg and the assertion macros in the defines header.
`include "multi_channel_software_watchdog_unit_defines.svh"

module mcswd_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_operation,
   input  logic [mcswd_pkg::NAME_W-1:0]           req_channel_name,
   input  logic [mcswd_pkg::HANDLE_W-1:0]         req_channel_handle,
   input  logic [mcswd_pkg::CNT_W-1:0]            reload,
   input  logic [mcswd_pkg::SLOTS-1:0]            used,
   input  logic [mcswd_pkg::CNT_W-1:0]            rd_count,
   input  logic [mcswd_pkg::NAME_W-1:0]           rd_label,
   output logic [mcswd_pkg::SLOT_W-1:0]           rd_addr,
   output mcswd_pkg::wr_req_type                  wr,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [mcswd_pkg::HANDLE_W-1:0]         rsp_assigned_handle,
   output logic                                   rsp_reboot_request,
   output logic [mcswd_pkg::EXP_W-1:0]            rsp_expired_count
);

   mcswd_pkg::state_type               state_ff, state_in;
   mcswd_pkg::op_type                  op_ff;
   logic [mcswd_pkg::SLOT_W-1:0]       idx_ff, idx_in;
   logic                               pipe_vld_ff;
   logic [mcswd_pkg::SLOT_W-1:0]       pipe_idx_ff;
   logic [mcswd_pkg::NAME_W-1:0]       name_ff;
   logic [mcswd_pkg::HANDLE_W-1:0]     handle_ff;
   logic                               dup_ff;
   logic                               found_ff;
   logic [mcswd_pkg::SLOT_W-1:0]       free_ff;
   logic [mcswd_pkg::EXP_W-1:0]        exp_ff;
   logic                               rsp_strobe_ff;
   mcswd_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [mcswd_pkg::HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic                               rsp_reboot_ff, rsp_reboot_in;
   logic [mcswd_pkg::EXP_W-1:0]        rsp_expired_ff, rsp_expired_in;
   logic                               accept;
   logic                               handle_ok;
   logic                               reg_ok;
   logic                               pipe_used;

   assign accept    = (state_ff == mcswd_pkg::ST_IDLE) && start;
   assign handle_ok = (32'(handle_ff) < 32'(mcswd_pkg::SLOTS))
                      && used[mcswd_pkg::SLOT_W'(handle_ff)];
   assign reg_ok    = !dup_ff && found_ff;
   assign pipe_used = used[pipe_idx_ff];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         mcswd_pkg::ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               if (req_operation inside {mcswd_pkg::OP_REGISTER, mcswd_pkg::OP_TICK}) begin
                  state_in = mcswd_pkg::ST_WALK;
               end else begin
                  state_in = mcswd_pkg::ST_DONE;
               end
            end
         end
         mcswd_pkg::ST_WALK: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == mcswd_pkg::SLOT_W'(mcswd_pkg::SLOTS - 1)) begin
               state_in = mcswd_pkg::ST_DRAIN;
            end
         end
         mcswd_pkg::ST_DRAIN: begin
            state_in = mcswd_pkg::ST_DONE;
         end
         mcswd_pkg::ST_DONE: begin
            state_in = mcswd_pkg::ST_IDLE;
         end
         default: begin
            state_in = mcswd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy    = (state_ff != mcswd_pkg::ST_IDLE);
      rd_addr = idx_ff;
      wr      = '0;
      if (pipe_vld_ff && (op_ff == mcswd_pkg::OP_TICK) && pipe_used && (rd_count != '0)) begin
         wr.en    = 1'b1;
         wr.addr  = pipe_idx_ff;
         wr.count = rd_count - 1'b1;
      end
      if (state_ff == mcswd_pkg::ST_DONE) begin
         case (op_ff)
            mcswd_pkg::OP_REGISTER: begin
               if (reg_ok) begin
                  wr.en       = 1'b1;
                  wr.label_en = 1'b1;
                  wr.addr     = free_ff;
                  wr.count    = reload;
                  wr.label    = name_ff;
               end
            end
            mcswd_pkg::OP_FEED: begin
               if (handle_ok) begin
                  wr.en    = 1'b1;
                  wr.addr  = mcswd_pkg::SLOT_W'(handle_ff);
                  wr.count = reload;
               end
            end
            default: begin
               wr.en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in  = mcswd_pkg::STAT_OK;
      rsp_handle_in  = '0;
      rsp_reboot_in  = 1'b0;
      rsp_expired_in = '0;
      case (op_ff)
         mcswd_pkg::OP_REGISTER: begin
            if (dup_ff) begin
               rsp_status_in = mcswd_pkg::STAT_DUPLICATE;
            end else if (!found_ff) begin
               rsp_status_in = mcswd_pkg::STAT_FULL;
            end else begin
               rsp_handle_in = mcswd_pkg::HANDLE_W'(free_ff);
            end
         end
         mcswd_pkg::OP_FEED: begin
            if (!handle_ok) begin
               rsp_status_in = mcswd_pkg::STAT_BAD_HANDLE;
            end
         end
         mcswd_pkg::OP_TICK: begin
            rsp_reboot_in  = (exp_ff != '0);
            rsp_expired_in = exp_ff;
         end
         default: begin
            rsp_status_in = mcswd_pkg::STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcswd_pkg::ST_IDLE;
         pipe_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pipe_vld_ff   <= (state_ff == mcswd_pkg::ST_WALK);
         rsp_strobe_ff <= (state_ff == mcswd_pkg::ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pipe_idx_ff <= idx_ff;
      if (accept) begin
         op_ff     <= mcswd_pkg::op_type'(req_operation);
         name_ff   <= mcswd_pkg::trim_name(req_channel_name);
         handle_ff <= req_channel_handle;
         dup_ff    <= 1'b0;
         found_ff  <= 1'b0;
         free_ff   <= '0;
         exp_ff    <= '0;
      end else if (pipe_vld_ff) begin
         if (op_ff == mcswd_pkg::OP_REGISTER) begin
            if (pipe_used && (rd_label == name_ff)) begin
               dup_ff <= 1'b1;
            end
            if (!pipe_used && !found_ff) begin
               found_ff <= 1'b1;
               free_ff  <= pipe_idx_ff;
            end
         end
         if ((op_ff == mcswd_pkg::OP_TICK) && pipe_used && (rd_count == '0)) begin
            exp_ff <= exp_ff + 1'b1;
         end
      end
      if (state_ff == mcswd_pkg::ST_DONE) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_handle_ff  <= rsp_handle_in;
         rsp_reboot_ff  <= rsp_reboot_in;
         rsp_expired_ff <= rsp_expired_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_assigned_handle = rsp_handle_ff;
   assign rsp_reboot_request  = rsp_reboot_ff;
   assign rsp_expired_count   = rsp_expired_ff;

   `MCSWD_ASSERT_IMP(a_idle_pipe_empty, state_ff == mcswd_pkg::ST_IDLE, !pipe_vld_ff)
   `MCSWD_ASSERT_NXT(a_walk_feeds_pipe, state_ff == mcswd_pkg::ST_WALK, pipe_vld_ff)
   `MCSWD_ASSERT_IMP(a_strobe_after_done, rsp_strobe_ff, $past(state_ff) == mcswd_pkg::ST_DONE)
   `MCSWD_ASSERT_IMP(a_expired_bounded, 1'b1, 32'(exp_ff) <= 32'(mcswd_pkg::SLOTS))

endmodule

>>> rtl/multi_channel_software_watchdog_unit.sv
// Top level of the multi-channel watchdog: reload register, sequencer and slot table.
// Depends on mcswd_pkg, mcswd_seq and mcswd_slot_store.
//
// Usage. An item is taken when start is high while busy is low; its operation
// selects register (name in req_channel_name), feed (slot in req_channel_handle)
// or one tick. Every item gives exactly one result, shown for a single cycle
// with rsp_strobe high; the receiver cannot hold it off, so it must sample then.
// Register and tick walk all slots through one registered read port, one slot a
// cycle, then drain the read pipe before the result strobe; busy clears in the
// strobe cycle; no new item is taken before then. Feed and an unknown operation
// skip the walk and go straight to the done state, which registers the strobe.
// The csr_ channel writes the reload value; it is ready whenever busy is low.
// Reset (synchronous, active high) frees every slot, sets the reload value to
// ten and leaves the block idle; counters and names need no clearing pass.
module multi_channel_software_watchdog_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_operation,
   input  logic [mcswd_pkg::NAME_W-1:0]           req_channel_name,
   input  logic [mcswd_pkg::HANDLE_W-1:0]         req_channel_handle,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [mcswd_pkg::HANDLE_W-1:0]         rsp_assigned_handle,
   output logic                                   rsp_reboot_request,
   output logic [mcswd_pkg::EXP_W-1:0]            rsp_expired_count,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mcswd_pkg::CNT_W-1:0]            csr_data
);

   logic [mcswd_pkg::CNT_W-1:0]  reload_ff;
   logic [mcswd_pkg::SLOTS-1:0]  used;
   logic [mcswd_pkg::CNT_W-1:0]  rd_count;
   logic [mcswd_pkg::NAME_W-1:0] rd_label;
   logic [mcswd_pkg::SLOT_W-1:0] rd_addr;
   mcswd_pkg::wr_req_type        wr;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= mcswd_pkg::RELOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         reload_ff <= csr_data;
      end
   end

   mcswd_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_channel_name    (req_channel_name),
      .req_channel_handle  (req_channel_handle),
      .reload              (reload_ff),
      .used                (used),
      .rd_count            (rd_count),
      .rd_label            (rd_label),
      .rd_addr             (rd_addr),
      .wr                  (wr),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_assigned_handle (rsp_assigned_handle),
      .rsp_reboot_request  (rsp_reboot_request),
      .rsp_expired_count   (rsp_expired_count)
   );

   mcswd_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_count (rd_count),
      .rd_label (rd_label),
      .used     (used)
   );

endmodule

>>> tb/multi_channel_software_watchdog_unit_test.sv
// Self-checking testbench for the multi-channel watchdog: drives register, feed, tick and
// no-op items and reload writes, predicts every result and checks it field by field.
// Depends on mcswd_pkg and the RTL of multi_channel_software_watchdog_unit.
module multi_channel_software_watchdog_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mcswd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 30;

   typedef struct {
      bit                  is_setting;
      logic [CNT_W-1:0]    setting;
      op_type              op;
      logic [NAME_W-1:0]   name;
      logic [HANDLE_W-1:0] handle;
   } job_type;

   typedef struct {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic                reboot;
      logic [EXP_W-1:0]    expired;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_operation = 2'd0;
   logic [NAME_W-1:0]   req_channel_name = '0;
   logic [HANDLE_W-1:0] req_channel_handle = '0;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [HANDLE_W-1:0] rsp_assigned_handle;
   logic                rsp_reboot_request;
   logic [EXP_W-1:0]    rsp_expired_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data = '0;

   job_type             pending_jobs[$];
   reply_type           replies_due[$];
   logic [NAME_W-1:0]   name_pool[$];
   int                  items_taken = 0;
   int                  replies_seen = 0;
   int                  quiet_cycles = 0;
   int                  mismatches = 0;

   logic                chan_used[SLOTS];
   logic [CNT_W-1:0]    chan_count[SLOTS];
   logic [NAME_W-1:0]   chan_name[SLOTS];
   logic [CNT_W-1:0]    reload_setting;

   multi_channel_software_watchdog_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_channel_name    (req_channel_name),
      .req_channel_handle  (req_channel_handle),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_assigned_handle (rsp_assigned_handle),
      .rsp_reboot_request  (rsp_reboot_request),
      .rsp_expired_count   (rsp_expired_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [NAME_W-1:0] clip_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      int                n;
      kept = '0;
      n = 0;
      while (n < NAME_BYTES && raw[8*n +: 8] != 8'h00) begin
         kept[8*n +: 8] = raw[8*n +: 8];
         n++;
      end
      return kept;
   endfunction

   function automatic reply_type apply_to_table(input op_type op,
                                                input logic [NAME_W-1:0] raw,
                                                input logic [HANDLE_W-1:0] h);
      reply_type         r;
      logic [NAME_W-1:0] key;
      bit                clash;
      int                free_slot;
      r = '{STAT_OK, '0, 1'b0, '0};
      case (op)
         OP_REGISTER: begin
            key = clip_name(raw);
            clash = 0;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (chan_used[i]) begin
                  if (chan_name[i] == key) clash = 1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (clash) begin
               r.status = STAT_DUPLICATE;
            end else if (free_slot < 0) begin
               r.status = STAT_FULL;
            end else begin
               chan_used[free_slot] = 1'b1;
               chan_count[free_slot] = reload_setting;
               chan_name[free_slot] = key;
               r.handle = HANDLE_W'(free_slot);
            end
         end
         OP_FEED: begin
            if (int'(h) >= SLOTS || !chan_used[h]) begin
               r.status = STAT_BAD_HANDLE;
            end else begin
               chan_count[h] = reload_setting;
            end
         end
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (chan_used[i]) begin
                  if (chan_count[i] == '0) r.expired = r.expired + 1'b1;
                  else chan_count[i] = chan_count[i] - 1'b1;
               end
            end
            r.reboot = (r.expired != '0);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic add_item(input op_type op, input logic [NAME_W-1:0] name,
                           input logic [HANDLE_W-1:0] h);
      pending_jobs.push_back('{1'b0, '0, op, name, h});
   endtask

   task automatic add_setting(input logic [CNT_W-1:0] value);
      pending_jobs.push_back('{1'b1, value, OP_NONE, '0, '0});
   endtask

   function automatic logic [NAME_W-1:0] random_name();
      logic [NAME_W-1:0] n;
      int                cut;
      n = {$urandom, $urandom};
      if ($urandom_range(2) == 0) begin
         cut = $urandom_range(NAME_BYTES - 1);
         n[8*cut +: 8] = 8'h00;
      end
      return n;
   endfunction

   task automatic add_random_item();
      int                pick;
      logic [NAME_W-1:0] name;
      pick = $urandom_range(99);
      name = random_name();
      if (name_pool.size() > 0 && $urandom_range(99) < 40) begin
         name = name_pool[$urandom_range(name_pool.size() - 1)];
      end else begin
         name_pool.push_back(name);
      end
      if (pick < 18) add_item(OP_REGISTER, name, HANDLE_W'($urandom_range(15)));
      else if (pick < 55) add_item(OP_FEED, name, HANDLE_W'($urandom_range(15)));
      else if (pick < 90) add_item(OP_TICK, name, HANDLE_W'($urandom_range(15)));
      else add_item(OP_NONE, name, HANDLE_W'($urandom_range(15)));
   endtask

   // Driver: one item or one reload write at a time; a reload write waits until
   // every result of earlier items has come back.
   always @(posedge clock) begin
      logic keep_start, keep_setting, launch_item, launch_setting, hold_off;
      job_type job;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         keep_start = start && busy;
         keep_setting = csr_valid && !csr_ready;
         if (start && !busy) items_taken++;
         launch_item = 1'b0;
         launch_setting = 1'b0;
         hold_off = ($urandom_range(99) < 37) && !(items_taken >= 400 && items_taken < 650);
         if (!keep_start && !keep_setting && !hold_off && pending_jobs.size() > 0) begin
            if (!pending_jobs[0].is_setting) begin
               launch_item = 1'b1;
            end else if (replies_seen == items_taken && !busy) begin
               launch_setting = 1'b1;
            end
         end
         if (launch_item || launch_setting) begin
            job = pending_jobs.pop_front();
            if (launch_item) begin
               req_operation <= job.op;
               req_channel_name <= job.name;
               req_channel_handle <= job.handle;
            end else begin
               csr_data <= job.setting;
            end
         end
         start <= keep_start || launch_item;
         csr_valid <= keep_setting || launch_setting;
      end
   end

   // Monitor: predicts each accepted item and checks each strobed result.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) chan_used[i] = 1'b0;
         reload_setting = RELOAD_RESET;
         replies_due.delete();
         replies_seen <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               note_mismatch("result with no item outstanding");
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status)
                  note_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_assigned_handle !== want.handle)
                  note_mismatch($sformatf("handle %0d, expected %0d",
                                          rsp_assigned_handle, want.handle));
               if (rsp_reboot_request !== want.reboot)
                  note_mismatch($sformatf("reboot %0b, expected %0b",
                                          rsp_reboot_request, want.reboot));
               if (rsp_expired_count !== want.expired)
                  note_mismatch($sformatf("expired %0d, expected %0d",
                                          rsp_expired_count, want.expired));
            end
            replies_seen <= replies_seen + 1;
         end
         if (csr_valid && csr_ready) reload_setting = csr_data;
         if (start && !busy)
            replies_due.push_back(apply_to_table(op_type'(req_operation), req_channel_name,
                                                 req_channel_handle));
         if (rsp_strobe || (start && !busy) || (csr_valid && csr_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CNT_W-1:0] phase_reload[8];
      phase_reload = '{16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 16'd4, 16'd0};
      phase_reload[3] = CNT_W'($urandom_range(7));
      phase_reload[4] = CNT_W'($urandom);
      phase_reload[5] = CNT_W'($urandom_range(3));

      add_setting(16'd3);
      add_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
      add_item(OP_TICK, '0, '0);
      add_item(OP_FEED, '0, 4'h0);
      add_item(OP_FEED, '0, 4'hF);
      add_item(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      // A name with bytes after its terminator matches the same name without them.
      add_item(OP_REGISTER, 64'h5A00_7700_0000_4142, '0);
      add_item(OP_REGISTER, 64'h0000_0000_0000_4142, '0);
      add_item(OP_REGISTER, 64'h0000_0000_0000_0000, '0);
      add_item(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, '0);
      add_item(OP_FEED, '0, 4'h1);
      repeat (4) add_item(OP_TICK, '0, '0);
      add_item(OP_REGISTER, 64'h8000_0000_0000_0001, '0);
      add_item(OP_NONE, '0, '0);
      add_setting(16'd0);
      add_item(OP_REGISTER, 64'h0000_0000_0000_1234, '0);
      add_item(OP_FEED, '0, 4'h4);
      add_item(OP_TICK, '0, '0);
      add_item(OP_FEED, '0, 4'h3);
      add_item(OP_TICK, '0, '0);
      add_item(OP_FEED, '0, 4'h7);

      foreach (phase_reload[p]) begin
         add_setting(phase_reload[p]);
         repeat (154) add_random_item();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_jobs.size() == 0 && !start && !csr_valid && replies_due.size() == 0)
             && quiet_cycles < QUIET_LIMIT)
         @(negedge clock);
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multi_channel_software_watchdog_unit test failed");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (replies_due.size() != 0) note_mismatch("results still outstanding at the end");
         if (mismatches == 0) begin
            $display("multi_channel_software_watchdog_unit test passed");
         end else begin
            $display("multi_channel_software_watchdog_unit test failed");
         end
      end
      $finish;
   end

endmodule
